FILE: rtl/core/pfa_pkg.sv
// shared constants and types of the partition fit allocator
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int MAX_PARTS    = 16;
    localparam int IDX_BITS     = $clog2(MAX_PARTS);
    localparam int CNT_BITS     = $clog2(MAX_PARTS + 1);
    localparam int ADDR_BITS    = 16;
    localparam int SIZE_BITS    = ADDR_BITS + 1;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_FIT_MODE    = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_MEMORY_SIZE = CFG_IDX_BITS'(1);

    localparam logic [SIZE_BITS-1:0] MEM_RESET = SIZE_BITS'(4096);
    localparam logic [SIZE_BITS-1:0] MEM_TOP   = SIZE_BITS'(1) << ADDR_BITS;

    localparam logic MODE_FIRST = 1'b0;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_BADSIZE = 2'd3;

    typedef enum logic [0:0] {
        ALU_SUB,
        ALU_ADD
    } alu_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FETCH,
        S_FIT,
        S_BEST,
        S_REM,
        S_ADD,
        S_SHREAD,
        S_SHWRITE,
        S_WRREM,
        S_WRSEL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] base;
        logic [SIZE_BITS-1:0] size;
        logic                 busy;
    } part_entry_t;

    typedef struct packed {
        logic                rd_en;
        logic [IDX_BITS-1:0] rd_addr;
        logic                wr_en;
        logic [IDX_BITS-1:0] wr_addr;
        part_entry_t         wr_data;
    } tbl_req_t;

endpackage

FILE: rtl/core/partition_fit_allocator_unit.sv
// partition fit allocator top level: configuration registers and core wiring
// a zero size goes straight to the result; else entries are fetched and tested in turn,
// best fit compares each later fit, and a split moves later entries up before its writes
// one request at a time, the next accepted in the cycle after its result beat
// the receiver cannot stall: each result beat is shown with done for one cycle
// reset: first fit, memory size 4096, table holds one free partition at base 0
`timescale 1ns / 1ps

module partition_fit_allocator_unit
    import pfa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [SIZE_BITS-1:0]    request_size,
    output logic                    done,
    output logic [ADDR_BITS-1:0]    alloc_base,
    output logic [1:0]              status,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [SIZE_BITS-1:0]    cfg_data
);

    logic                 fit_mode_reg, fit_mode_next;
    logic [SIZE_BITS-1:0] mem_size_reg, mem_size_next;
    logic [SIZE_BITS-1:0] mem_clamped;
    logic                 init;

    tbl_req_t             tbl_req;
    part_entry_t          tbl_rd_data;
    alu_op_t              alu_op;
    logic [SIZE_BITS-1:0] alu_a;
    logic [SIZE_BITS-1:0] alu_b;
    logic [SIZE_BITS-1:0] alu_result;
    logic                 alu_borrow;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            mem_clamped = SIZE_BITS'(1);
        end
        else if (cfg_data > MEM_TOP)
        begin
            mem_clamped = MEM_TOP;
        end
        else
        begin
            mem_clamped = cfg_data;
        end
    end

    assign init = cfg_we && (cfg_index == REG_MEMORY_SIZE);

    always_comb
    begin
        fit_mode_next = fit_mode_reg;
        mem_size_next = mem_size_reg;
        if (cfg_we && (cfg_index == REG_FIT_MODE))
        begin
            fit_mode_next = cfg_data[0];
        end
        if (init)
        begin
            mem_size_next = mem_clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg <= MODE_FIRST;
            mem_size_reg <= MEM_RESET;
        end
        else
        begin
            fit_mode_reg <= fit_mode_next;
            mem_size_reg <= mem_size_next;
        end
    end

    pfa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .request_size (request_size),
        .fit_mode     (fit_mode_reg),
        .memory_size  (mem_size_reg),
        .init         (init),
        .busy         (busy),
        .done         (done),
        .alloc_base   (alloc_base),
        .status       (status),
        .tbl_req      (tbl_req),
        .tbl_rd_data  (tbl_rd_data),
        .alu_op       (alu_op),
        .alu_a        (alu_a),
        .alu_b        (alu_b),
        .alu_result   (alu_result),
        .alu_borrow   (alu_borrow)
    );

    pfa_table u_table (
        .clk     (clk),
        .req     (tbl_req),
        .rd_data (tbl_rd_data)
    );

    pfa_alu u_alu (
        .op     (alu_op),
        .a      (alu_a),
        .b      (alu_b),
        .result (alu_result),
        .borrow (alu_borrow)
    );

endmodule

FILE: rtl/core/pfa_alu.sv
// shared add / subtract unit with borrow flag
`timescale 1ns / 1ps

module pfa_alu
    import pfa_pkg::*;
(
    input  alu_op_t              op,
    input  logic [SIZE_BITS-1:0] a,
    input  logic [SIZE_BITS-1:0] b,
    output logic [SIZE_BITS-1:0] result,
    output logic                 borrow
);

    logic                 sub;
    logic [SIZE_BITS-1:0] b_in;
    logic                 carry;

    assign sub  = (op == ALU_SUB);
    assign b_in = sub ? ~b : b;
    assign {carry, result} = {1'b0, a} + {1'b0, b_in} + {{SIZE_BITS{1'b0}}, sub};
    // borrow set means a < b on a subtract
    assign borrow = sub & ~carry;

endmodule

FILE: rtl/core/pfa_table.sv
// partition table memory, one write and one registered read port
`timescale 1ns / 1ps

module pfa_table
    import pfa_pkg::*;
(
    input  logic        clk,
    input  tbl_req_t    req,
    output part_entry_t rd_data
);

    part_entry_t mem [MAX_PARTS];
    part_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/pfa_ctrl.sv
// allocation sequencer: table scan, remainder split and entry shift
`timescale 1ns / 1ps

module pfa_ctrl
    import pfa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SIZE_BITS-1:0] request_size,
    input  logic                 fit_mode,
    input  logic [SIZE_BITS-1:0] memory_size,
    input  logic                 init,
    output logic                 busy,
    output logic                 done,
    output logic [ADDR_BITS-1:0] alloc_base,
    output logic [1:0]           status,
    output tbl_req_t             tbl_req,
    input  part_entry_t          tbl_rd_data,
    output alu_op_t              alu_op,
    output logic [SIZE_BITS-1:0] alu_a,
    output logic [SIZE_BITS-1:0] alu_b,
    input  logic [SIZE_BITS-1:0] alu_result,
    input  logic                 alu_borrow
);

    state_t               state_reg, state_next;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic                 fresh_reg, fresh_next;
    logic [CNT_BITS-1:0]  scan_reg, scan_next;
    logic [CNT_BITS-1:0]  shift_reg, shift_next;
    logic                 have_reg, have_next;
    logic [SIZE_BITS-1:0] req_reg, req_next;
    logic [IDX_BITS-1:0]  sel_idx_reg, sel_idx_next;
    logic [SIZE_BITS-1:0] sel_size_reg, sel_size_next;
    logic [ADDR_BITS-1:0] sel_base_reg, sel_base_next;
    logic [SIZE_BITS-1:0] rem_size_reg, rem_size_next;
    logic [ADDR_BITS-1:0] rem_base_reg, rem_base_next;
    logic [1:0]           status_reg, status_next;
    logic [ADDR_BITS-1:0] base_out_reg, base_out_next;

    part_entry_t          cur;
    logic [CNT_BITS-1:0]  scan_inc;
    logic [CNT_BITS-1:0]  after_sel;
    logic [CNT_BITS-1:0]  shift_dec;
    logic                 fits;
    logic                 advance;

    // entry 0 reads as one free partition until the first allocation writes it
    always_comb
    begin
        if (fresh_reg && (scan_reg == '0))
        begin
            cur = '{base: '0, size: memory_size, busy: 1'b0};
        end
        else
        begin
            cur = tbl_rd_data;
        end
    end

    assign scan_inc  = scan_reg + CNT_BITS'(1);
    assign after_sel = {1'b0, sel_idx_reg} + CNT_BITS'(1);
    assign shift_dec = shift_reg - CNT_BITS'(1);
    assign fits      = ~cur.busy & ~alu_borrow;

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        fresh_next    = fresh_reg;
        scan_next     = scan_reg;
        shift_next    = shift_reg;
        have_next     = have_reg;
        req_next      = req_reg;
        sel_idx_next  = sel_idx_reg;
        sel_size_next = sel_size_reg;
        sel_base_next = sel_base_reg;
        rem_size_next = rem_size_reg;
        rem_base_next = rem_base_reg;
        status_next   = status_reg;
        base_out_next = base_out_reg;
        tbl_req       = '0;
        alu_op        = ALU_SUB;
        alu_a         = '0;
        alu_b         = '0;
        advance       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (init)
                begin
                    count_next = CNT_BITS'(1);
                    fresh_next = 1'b1;
                end
                if (start)
                begin
                    req_next  = request_size;
                    scan_next = '0;
                    have_next = 1'b0;
                    if (request_size == '0)
                    begin
                        status_next   = ST_BADSIZE;
                        base_out_next = '0;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = scan_reg[IDX_BITS-1:0];
                state_next      = S_FIT;
            end
            S_FIT:
            begin
                alu_a = cur.size;
                alu_b = req_reg;
                if (fits && (fit_mode == MODE_FIRST))
                begin
                    sel_idx_next  = scan_reg[IDX_BITS-1:0];
                    sel_size_next = cur.size;
                    sel_base_next = cur.base;
                    state_next    = S_REM;
                end
                else if (fits && !have_reg)
                begin
                    sel_idx_next  = scan_reg[IDX_BITS-1:0];
                    sel_size_next = cur.size;
                    sel_base_next = cur.base;
                    have_next     = 1'b1;
                    advance       = 1'b1;
                end
                else if (fits)
                begin
                    state_next = S_BEST;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_BEST:
            begin
                // strictly smaller wins, so ties keep the lower index
                alu_a = cur.size;
                alu_b = sel_size_reg;
                if (alu_borrow)
                begin
                    sel_idx_next  = scan_reg[IDX_BITS-1:0];
                    sel_size_next = cur.size;
                    sel_base_next = cur.base;
                end
                advance = 1'b1;
            end
            S_REM:
            begin
                alu_a         = sel_size_reg;
                alu_b         = req_reg;
                rem_size_next = alu_result;
                if (alu_result == '0)
                begin
                    state_next = S_WRSEL;
                end
                else if (count_reg == CNT_BITS'(MAX_PARTS))
                begin
                    status_next   = ST_FULL;
                    base_out_next = '0;
                    state_next    = S_DONE;
                end
                else
                begin
                    shift_next = count_reg;
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                alu_op        = ALU_ADD;
                alu_a         = {1'b0, sel_base_reg};
                alu_b         = req_reg;
                rem_base_next = alu_result[ADDR_BITS-1:0];
                if (shift_reg > after_sel)
                begin
                    state_next = S_SHREAD;
                end
                else
                begin
                    state_next = S_WRREM;
                end
            end
            S_SHREAD:
            begin
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = shift_dec[IDX_BITS-1:0];
                state_next      = S_SHWRITE;
            end
            S_SHWRITE:
            begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = shift_reg[IDX_BITS-1:0];
                tbl_req.wr_data = tbl_rd_data;
                shift_next      = shift_dec;
                if (shift_dec > after_sel)
                begin
                    state_next = S_SHREAD;
                end
                else
                begin
                    state_next = S_WRREM;
                end
            end
            S_WRREM:
            begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = after_sel[IDX_BITS-1:0];
                tbl_req.wr_data = '{base: rem_base_reg, size: rem_size_reg, busy: 1'b0};
                count_next      = count_reg + CNT_BITS'(1);
                state_next      = S_WRSEL;
            end
            S_WRSEL:
            begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = sel_idx_reg;
                tbl_req.wr_data = '{base: sel_base_reg, size: req_reg, busy: 1'b1};
                fresh_next      = 1'b0;
                status_next     = ST_OK;
                base_out_next   = sel_base_reg;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (advance)
        begin
            if (scan_inc == count_reg)
            begin
                if (have_next)
                begin
                    state_next = S_REM;
                end
                else
                begin
                    status_next   = ST_NOFIT;
                    base_out_next = '0;
                    state_next    = S_DONE;
                end
            end
            else
            begin
                scan_next  = scan_inc;
                state_next = S_FETCH;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CNT_BITS'(1);
            fresh_reg <= 1'b1;
            scan_reg  <= '0;
            shift_reg <= '0;
            have_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            fresh_reg <= fresh_next;
            scan_reg  <= scan_next;
            shift_reg <= shift_next;
            have_reg  <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        sel_idx_reg  <= sel_idx_next;
        sel_size_reg <= sel_size_next;
        sel_base_reg <= sel_base_next;
        rem_size_reg <= rem_size_next;
        rem_base_reg <= rem_base_next;
        status_reg   <= status_next;
        base_out_reg <= base_out_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = (state_reg == S_DONE);
    assign alloc_base = base_out_reg;
    assign status     = status_reg;

endmodule

FILE: rtl/core/pfa_checker.sv
// port-level checks for the partition fit allocator, bound to the top level
`timescale 1ns / 1ps

module pfa_checker
    import pfa_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic [ADDR_BITS-1:0] alloc_base,
    input logic [1:0]           status
);

    // an accepted request raises busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // result beats never come two in a row
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat longer than one cycle");

    // the result beat ends the request
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy ##1 !busy)
        else $error("block still busy after result beat");

    // error results carry a zero base
    a_err_base: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (alloc_base == '0))
        else $error("nonzero base on error result");

endmodule

bind partition_fit_allocator_unit pfa_checker u_pfa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .alloc_base (alloc_base),
    .status     (status)
);
